// ----- rtl/usage_count_lru_table_defines.svh -----
// assertion macros for the usage count lru table
// no dependencies; taken in by the rtl files that assert
`ifndef USAGE_COUNT_LRU_TABLE_DEFINES_SVH
`define USAGE_COUNT_LRU_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define UCLT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("uclt assertion failed");

// next-cycle implication, disabled during reset
`define UCLT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("uclt assertion failed");

`endif

// ----- rtl/uclt_pkg.sv -----
// shared types and constants for the usage count lru table
// no dependencies
`default_nettype none

package uclt_pkg;

	// default table depth
	localparam int TABLE_ENTRIES_DEF = 32;

	// operation codes
	localparam logic [1:0] OP_QUERY  = 2'd0;
	localparam logic [1:0] OP_RECORD = 2'd1;
	localparam logic [1:0] OP_DECAY  = 2'd2;

	// arithmetic constants
	localparam int          AGE_STEP  = 20;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam logic [21:0] PEN_BASE  = 22'd100;
	localparam logic [21:0] PEN_STEP  = 22'd40;

	// one table entry as stored in memory
	typedef struct packed {
		logic [31:0] phrase;
		logic [15:0] count;
		logic [31:0] stamp;
	} entry_t;

	// decay pipeline status toward the table controller
	typedef struct packed {
		logic wr_en;
		logic busy;
	} dec_stat_t;

endpackage

`default_nettype wire

// ----- rtl/uclt_decay.sv -----
// decay pipeline: ages one entry per cycle and produces its write-back
// depends on uclt_pkg
`default_nettype none

module uclt_decay #(
	parameter int IDX_W = 5
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_v,
	input  wire [IDX_W-1:0]      in_idx,
	input  wire uclt_pkg::entry_t in_ent,
	input  wire [31:0]           now,
	output uclt_pkg::dec_stat_t  stat,
	output logic [IDX_W-1:0]     wr_idx,
	output uclt_pkg::entry_t     wr_ent
);
	import uclt_pkg::*;

	// ages at or above this limit drop more than any count can hold
	localparam logic [31:0] AGE_LIMIT = 32'(AGE_STEP * 65536);
	// age / 20 = (age / 4) / 5, the latter via reciprocal 2^22 / 5 rounded up
	localparam int          Q_SHIFT   = 22;
	localparam logic [38:0] RECIP     = 39'(((1 << Q_SHIFT) + 4) / 5);

	logic             v_s2, v_s3;
	logic [IDX_W-1:0] idx_s2, idx_s3;
	entry_t           ent_s2, ent_s3;
	logic             big_s2, big_s3;
	logic [18:0]      x_s2;
	logic [15:0]      q_s3;

	logic [31:0] age;
	logic [38:0] prod;
	logic        drop_nz;

	// age with clamp at zero
	assign age  = (now > in_ent.stamp) ? (now - in_ent.stamp) : 32'd0;
	assign prod = 39'(x_s2) * RECIP;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= in_v;
			v_s3 <= v_s2;
		end
	end

	// stage 2: age range and quotient operand; stage 3: quotient
	always_ff @(posedge clk) begin
		idx_s2 <= in_idx;
		ent_s2 <= in_ent;
		big_s2 <= (age >= AGE_LIMIT);
		x_s2   <= age[20:2];
		idx_s3 <= idx_s2;
		ent_s3 <= ent_s2;
		big_s3 <= big_s2;
		q_s3   <= prod[37:22];
	end

	// write-back of an aged entry
	always_comb begin
		drop_nz      = big_s3 || (q_s3 != 16'd0);
		stat.wr_en   = v_s3 && (ent_s3.count != 16'd0) && drop_nz;
		stat.busy    = v_s2 || v_s3;
		wr_idx       = idx_s3;
		wr_ent       = ent_s3;
		wr_ent.stamp = now;
		if (big_s3 || (q_s3 > ent_s3.count))
			wr_ent.count = 16'd0;
		else
			wr_ent.count = ent_s3.count - q_s3;
	end

endmodule

`default_nettype wire

// ----- rtl/usage_count_lru_table.sv -----
// usage count lru table: every operation sweeps the entry memory, one read a cycle.
// each operation is taken in ST_IDLE, reads all TABLE_ENTRIES in ST_SCAN, waits in ST_DRAIN for
// the read stage and decay pipeline to empty, writes in ST_WRITE for a record, and answers in ST_DONE;
// the unused code skips the sweep and goes straight to ST_DONE.
// a new item is taken only in ST_IDLE, once the last result is registered; sweeps use the single read port.
// reset: valid bits per entry clear at once, unwritten entries read as zero;
`default_nettype none

`include "usage_count_lru_table_defines.svh"

module usage_count_lru_table #(
	parameter int TABLE_ENTRIES = uclt_pkg::TABLE_ENTRIES_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  operation,
	input  wire  [31:0] key_id,
	input  wire  [31:0] turn,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [21:0] penalty_pct,
	output logic        hit
);
	import uclt_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_WRITE = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t           st_q;
	logic [1:0]       op_q;
	logic [31:0]      id_q, turn_q;
	logic [IDX_W-1:0] idx_q;

	// memory and read stage
	entry_t                   mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] vld_q;
	logic                     rd_v_s1, rd_vld_s1;
	logic [IDX_W-1:0]         rd_idx_s1;
	entry_t                   rd_ent_s1, cur_ent;

	// scan trackers
	logic             mt_q, zf_q;
	logic [IDX_W-1:0] mt_idx_q, zf_idx_q, lru_idx_q;
	logic [15:0]      mt_cnt_q;
	logic [31:0]      lru_last_q;

	// output register
	logic        out_valid_q, hit_q;
	logic [21:0] pen_q;

	logic             in_fire, rd_en, rec_we, mem_we, done_go;
	logic [IDX_W-1:0] rec_idx, wr_addr, dec_wr_idx;
	entry_t           rec_ent, wr_ent, dec_wr_ent;
	dec_stat_t        dec_stat;
	logic [21:0]      pen_mul;

	assign in_ready    = (st_q == ST_IDLE);
	assign in_fire     = in_valid && in_ready;
	assign rd_en       = (st_q == ST_SCAN);
	assign done_go     = (st_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;
	assign penalty_pct = pen_q;
	assign hit         = hit_q;
	assign cur_ent     = rd_vld_s1 ? rd_ent_s1 : '0;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			op_q   <= OP_QUERY;
			idx_q  <= '0;
			id_q   <= 32'd0;
			turn_q <= 32'd0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_fire) begin
						op_q   <= operation;
						id_q   <= key_id;
						turn_q <= turn;
						idx_q  <= '0;
						if (operation == OP_QUERY || operation == OP_RECORD ||
						    operation == OP_DECAY)
							st_q <= ST_SCAN;
						else
							st_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					if (idx_q == LAST_IDX)
						st_q <= ST_DRAIN;
					else
						idx_q <= idx_q + 1'b1;
				end
				ST_DRAIN: begin
					if (!rd_v_s1 && !dec_stat.busy)
						st_q <= (op_q == OP_RECORD) ? ST_WRITE : ST_DONE;
				end
				ST_WRITE: st_q <= ST_DONE;
				ST_DONE: begin
					if (done_go)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// entry memory: one read and one write port, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= wr_ent;
		rd_ent_s1 <= mem[idx_q];
		rd_vld_s1 <= vld_q[idx_q];
		rd_idx_s1 <= idx_q;
	end

	// per-entry valid bits and read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
			if (mem_we)
				vld_q[wr_addr] <= 1'b1;
		end
	end

	// match, free entry and lru tracking over the sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mt_q <= 1'b0;
			zf_q <= 1'b0;
		end else if (in_fire) begin
			mt_q <= 1'b0;
			zf_q <= 1'b0;
		end else if (rd_v_s1 && op_q != OP_DECAY) begin
			if (!mt_q && cur_ent.phrase == id_q)
				mt_q <= 1'b1;
			if (!zf_q && cur_ent.count == 16'd0)
				zf_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_s1 && op_q != OP_DECAY) begin
			if (!mt_q && cur_ent.phrase == id_q) begin
				mt_idx_q <= rd_idx_s1;
				mt_cnt_q <= cur_ent.count;
			end
			if (!zf_q && cur_ent.count == 16'd0)
				zf_idx_q <= rd_idx_s1;
			if (rd_idx_s1 == '0 || cur_ent.stamp < lru_last_q) begin
				lru_idx_q  <= rd_idx_s1;
				lru_last_q <= cur_ent.stamp;
			end
		end
	end

	// decay pipeline fed from the read stage
	uclt_decay #(
		.IDX_W (IDX_W)
	) u_decay (
		.clk    (clk),
		.arst_n (arst_n),
		.in_v   (rd_v_s1 && op_q == OP_DECAY),
		.in_idx (rd_idx_s1),
		.in_ent (cur_ent),
		.now    (turn_q),
		.stat   (dec_stat),
		.wr_idx (dec_wr_idx),
		.wr_ent (dec_wr_ent)
	);

	// record write-back: matched entry, else first free, else lru; muxed with the decay write-back
	always_comb begin
		rec_we         = (st_q == ST_WRITE);
		rec_idx        = mt_q ? mt_idx_q : (zf_q ? zf_idx_q : lru_idx_q);
		rec_ent.phrase = id_q;
		rec_ent.stamp  = turn_q;
		if (!mt_q)
			rec_ent.count = 16'd1;
		else if (mt_cnt_q == COUNT_MAX)
			rec_ent.count = COUNT_MAX;
		else
			rec_ent.count = mt_cnt_q + 16'd1;
		mem_we  = rec_we || dec_stat.wr_en;
		wr_addr = rec_we ? rec_idx : dec_wr_idx;
		wr_ent  = rec_we ? rec_ent : dec_wr_ent;
	end

	// result register
	assign pen_mul = 22'(mt_cnt_q) * PEN_STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_go) begin
			if (op_q == OP_QUERY)
				pen_q <= mt_q ? (PEN_BASE + pen_mul) : PEN_BASE;
			else
				pen_q <= 22'd0;
			hit_q <= (op_q == OP_QUERY || op_q == OP_RECORD) ? mt_q : 1'b0;
		end
	end

	// checks
	`UCLT_ASSERT_IMP(a_no_rw_clash, clk, arst_n, dec_stat.wr_en && rd_en, dec_wr_idx != idx_q)
	`UCLT_ASSERT_IMP(a_decay_wr_op, clk, arst_n, dec_stat.wr_en, op_q == OP_DECAY)
	`UCLT_ASSERT_IMP(a_write_quiet, clk, arst_n, rec_we, !rd_v_s1 && !dec_stat.busy)
	`UCLT_ASSERT_NXT(a_accept_next, clk, arst_n, in_fire, st_q == ST_SCAN || st_q == ST_DONE)

endmodule

`default_nettype wire
